### rtl/ldpm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ldpm_pkg
// Shared types, constants and saturating helpers for the lens distortion
// pixel map core.
// ---------------------------------------------------------------------------
package ldpm_pkg;

    // default image size
    localparam int DEF_IMAGE_WIDTH  = 512;
    localparam int DEF_IMAGE_HEIGHT = 424;

    // normalised values: signed Q.28, magnitude limited to 2^56 - 1
    localparam int Q_W  = 57;
    localparam int FRAC = 28;
    typedef logic signed [Q_W-1:0] t_q;

    localparam t_q Q_LIM = 57'shFF_FFFF_FFFF_FFFF;
    localparam t_q Q_ONE = 57'sh1000_0000;
    localparam logic signed [Q_W:0] Q_LIM_W = 58'shFF_FFFF_FFFF_FFFF;

    // quotient bits of the normalising division
    localparam int DIV_STEPS = 54;

    // output range, signed Q11.16
    localparam int OUT_W = 28;
    localparam logic signed [Q_W:0] OUT_MAX = 58'sh7FF_FFFF;
    localparam logic signed [Q_W:0] OUT_MIN = -58'sh800_0000;

    // register reset values
    localparam logic [25:0] RST_CENTER_X = 26'd16777216;
    localparam logic [25:0] RST_CENTER_Y = 26'd13893632;
    localparam logic [25:0] RST_FOCAL    = 26'd23920640;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_FOCAL_X       = 3'd2,
        REG_FOCAL_Y       = 3'd3,
        REG_RADIAL_FIRST  = 3'd4,
        REG_RADIAL_SECOND = 3'd5,
        REG_RADIAL_THIRD  = 3'd6,
        REG_TANGENTIAL    = 3'd7
    } t_reg_idx;

    // clamp a widened value to the Q.28 bound
    function automatic t_q sat_q(input logic signed [Q_W:0] v);
        t_q r;
        if (v > Q_LIM_W) begin
            r = Q_LIM;
        end else if (v < -Q_LIM_W) begin
            r = -Q_LIM;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // saturating sum
    function automatic t_q add_q(input t_q a, input t_q b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        return sat_q(s);
    endfunction

    // saturating doubling
    function automatic t_q dbl_q(input t_q a);
        logic signed [Q_W:0] s;
        s = {a, 1'b0};
        return sat_q(s);
    endfunction

    // add the centre and clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input t_q p, input logic [25:0] c);
        logic signed [Q_W:0]       s;
        logic signed [OUT_W-1:0]   r;
        s = {p[Q_W-1], p} + $signed({32'b0, c});
        if (s > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (s < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = s[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/ldpm_mulq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ldpm_mulq
// Pipelined Q.28 multiplier: exact product of magnitudes from four 28x28
// partial products, shifted right by 28 toward zero and saturated.
// One product per cycle.
// ---------------------------------------------------------------------------
module ldpm_mulq
    import ldpm_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_q   i_a,
    input  wire t_q   i_b,
    output t_q        o_p
);

    logic [55:0]  r_ma, r_mb;
    logic         r_neg1, r_neg2, r_neg3;
    logic [55:0]  r_p00, r_p01, r_p10, r_p11;
    logic [111:0] r_sum;
    t_q           r_p;
    t_q           n_ma, n_mb;
    logic [55:0]  n_mag;

    // stage 1: magnitudes and sign
    always_comb begin
        n_ma = i_a[Q_W-1] ? -i_a : i_a;
        n_mb = i_b[Q_W-1] ? -i_b : i_b;
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma[55:0];
        r_mb   <= n_mb[55:0];
        r_neg1 <= i_a[Q_W-1] ^ i_b[Q_W-1];
    end

    // stage 2: partial products
    always_ff @(posedge i_clk) begin
        r_p00  <= r_ma[27:0]  * r_mb[27:0];
        r_p01  <= r_ma[27:0]  * r_mb[55:28];
        r_p10  <= r_ma[55:28] * r_mb[27:0];
        r_p11  <= r_ma[55:28] * r_mb[55:28];
        r_neg2 <= r_neg1;
    end

    // stage 3: full product
    always_ff @(posedge i_clk) begin
        r_sum  <= 112'(r_p00) + (112'(r_p01) << 28) + (112'(r_p10) << 28)
                + (112'(r_p11) << 56);
        r_neg3 <= r_neg2;
    end

    // stage 4: shift, saturate, sign
    always_comb begin
        n_mag = (r_sum[111:84] != '0) ? Q_LIM[55:0] : r_sum[83:28];
    end

    always_ff @(posedge i_clk) begin
        r_p <= r_neg3 ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### rtl/lens_distortion_pixel_map_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lens_distortion_pixel_map_core
// Brown-Conrady distortion (three radial, two tangential terms) of one depth
// pixel coordinate, with the rounded linear map index of the result.
// ---------------------------------------------------------------------------
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+------------------
//  pixel in  | i_pixel_x, i_pixel_y                       | start high, busy low
//  result    | o_distorted_x/y, o_map_index, o_index_valid| o_done, one cycle
//  config    | i_cfg_index, i_cfg_wdata                   | i_cfg_we
//
// one pixel per clock; each result is taken in the cycle in which the o_done strobe
// is high, in the order of the transactions
// the normalising divider stages: entry, 54 quotient bits, sign
// after it: squares, radial polynomial, final products, scaling back, rounding
// synchronous reset empties the pipeline; busy is high only during reset
// the pipeline never stalls, results leave unconditionally
// ---------------------------------------------------------------------------
module lens_distortion_pixel_map_core
    import ldpm_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [8:0]        i_pixel_x,
    input  wire logic [8:0]        i_pixel_y,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [63:0]       i_cfg_wdata,
    output logic                   o_done,
    output logic signed [27:0]     o_distorted_x,
    output logic signed [27:0]     o_distorted_y,
    output logic [17:0]            o_map_index,
    output logic                   o_index_valid
);

    localparam int LAT = DIV_STEPS + 2 + 33;
    localparam logic [12:0] W_LIM = 13'(IMAGE_WIDTH);
    localparam logic [12:0] H_LIM = 13'(IMAGE_HEIGHT);

    // configuration registers
    logic [25:0]        r_center_x, r_center_y, r_focal_x, r_focal_y;
    logic signed [31:0] r_k1, r_k2, r_k3;
    logic [63:0]        r_tang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_focal_x  <= RST_FOCAL;
            r_focal_y  <= RST_FOCAL;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_tang     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CENTER_X:      r_center_x <= i_cfg_wdata[25:0];
                REG_CENTER_Y:      r_center_y <= i_cfg_wdata[25:0];
                REG_FOCAL_X:       r_focal_x  <= i_cfg_wdata[25:0];
                REG_FOCAL_Y:       r_focal_y  <= i_cfg_wdata[25:0];
                REG_RADIAL_FIRST:  r_k1       <= i_cfg_wdata[31:0];
                REG_RADIAL_SECOND: r_k2       <= i_cfg_wdata[31:0];
                REG_RADIAL_THIRD:  r_k3       <= i_cfg_wdata[31:0];
                REG_TANGENTIAL:    r_tang     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-axis views of the configuration, axis 0 is x
    logic [25:0] w_center [2];
    logic [25:0] w_focal  [2];
    logic [8:0]  w_pix    [2];
    t_q          w_focal_q [2];
    t_q          w_pa [2];
    t_q          w_pb [2];
    t_q          w_k1, w_k2, w_k3, w_p1, w_p2;

    assign w_center[0] = r_center_x;
    assign w_center[1] = r_center_y;
    assign w_focal[0]  = r_focal_x;
    assign w_focal[1]  = r_focal_y;
    assign w_pix[0]    = i_pixel_x;
    assign w_pix[1]    = i_pixel_y;
    assign w_k1 = {{25{r_k1[31]}}, r_k1};
    assign w_k2 = {{25{r_k2[31]}}, r_k2};
    assign w_k3 = {{25{r_k3[31]}}, r_k3};
    assign w_p1 = {{25{r_tang[31]}}, r_tang[31:0]};
    assign w_p2 = {{25{r_tang[63]}}, r_tang[63:32]};
    assign w_focal_q[0] = {31'b0, r_focal_x};
    assign w_focal_q[1] = {31'b0, r_focal_y};
    // tangential weights: x takes p2 on the radial term, y takes p1
    assign w_pa[0] = w_p2;
    assign w_pa[1] = w_p1;
    assign w_pb[0] = w_p1;
    assign w_pb[1] = w_p2;

    // transaction accept and valid line
    logic           w_accept;
    logic [LAT-1:0] r_vld;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // normalising divider: restoring, one quotient bit per stage
    logic [25:0]           r_rem  [2][DIV_STEPS+1];
    logic [DIV_STEPS-1:0]  r_qn   [2][DIV_STEPS+1];
    logic                  r_neg  [2][DIV_STEPS+1];
    logic                  r_zero [2][DIV_STEPS+1];
    logic [25:0]           n_rem  [2][DIV_STEPS+1];
    logic [DIV_STEPS-1:0]  n_qn   [2][DIV_STEPS+1];
    logic signed [26:0]    n_u    [2];
    logic signed [26:0]    n_mag  [2];
    t_q                    r_dq   [2];

    always_comb begin
        logic [26:0] t;
        logic        qb;
        for (int a = 0; a < 2; a++) begin
            n_u[a]   = $signed({2'b0, w_pix[a], 16'b0}) - $signed({1'b0, w_center[a]});
            n_mag[a] = n_u[a][26] ? -n_u[a] : n_u[a];
            n_rem[a][0] = '0;
            n_qn[a][0]  = {n_mag[a][25:0], 28'b0};
            for (int s = 0; s < DIV_STEPS; s++) begin
                t = {r_rem[a][s], r_qn[a][s][DIV_STEPS-1]};
                if (t >= {1'b0, w_focal[a]}) begin
                    n_rem[a][s+1] = 26'(t - {1'b0, w_focal[a]});
                    qb = 1'b1;
                end else begin
                    n_rem[a][s+1] = t[25:0];
                    qb = 1'b0;
                end
                n_qn[a][s+1] = {r_qn[a][s][DIV_STEPS-2:0], qb};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            r_rem[a][0]  <= n_rem[a][0];
            r_qn[a][0]   <= n_qn[a][0];
            r_neg[a][0]  <= n_u[a][26];
            r_zero[a][0] <= (n_u[a] == '0);
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[a][s+1]  <= n_rem[a][s+1];
                r_qn[a][s+1]   <= n_qn[a][s+1];
                r_neg[a][s+1]  <= r_neg[a][s];
                r_zero[a][s+1] <= r_zero[a][s];
            end
            // quotient sign, zero focal saturates
            if (r_zero[a][DIV_STEPS]) begin
                r_dq[a] <= '0;
            end else if (w_focal[a] == '0) begin
                r_dq[a] <= r_neg[a][DIV_STEPS] ? -Q_LIM : Q_LIM;
            end else if (r_neg[a][DIV_STEPS]) begin
                r_dq[a] <= -$signed({3'b0, r_qn[a][DIV_STEPS]});
            end else begin
                r_dq[a] <= $signed({3'b0, r_qn[a][DIV_STEPS]});
            end
        end
    end

    // squares and cross term
    t_q w_sq [2];
    t_q w_xy;

    ldpm_mulq u_sq_x (.i_clk(i_clk), .i_a(r_dq[0]), .i_b(r_dq[0]), .o_p(w_sq[0]));
    ldpm_mulq u_sq_y (.i_clk(i_clk), .i_a(r_dq[1]), .i_b(r_dq[1]), .o_p(w_sq[1]));
    ldpm_mulq u_xy   (.i_clk(i_clk), .i_a(r_dq[0]), .i_b(r_dq[1]), .o_p(w_xy));

    // r2, doubled terms, tangential sums
    t_q r_r2, r_dxy2;
    t_q r_dbl [2];
    t_q r_s   [2];

    always_ff @(posedge i_clk) begin
        r_r2   <= add_q(w_sq[0], w_sq[1]);
        r_dxy2 <= dbl_q(w_xy);
        for (int a = 0; a < 2; a++) begin
            r_dbl[a] <= dbl_q(w_sq[a]);
            r_s[a]   <= add_q(r_r2, r_dbl[a]);
        end
    end

    // radial polynomial, Horner form over three multipliers
    t_q w_m1, w_m2, w_m3;
    t_q r_kr1, r_kr2, r_kr;
    t_q r_r2d [10];

    ldpm_mulq u_poly1 (.i_clk(i_clk), .i_a(w_k3),  .i_b(r_r2),     .o_p(w_m1));
    ldpm_mulq u_poly2 (.i_clk(i_clk), .i_a(r_kr1), .i_b(r_r2d[4]), .o_p(w_m2));
    ldpm_mulq u_poly3 (.i_clk(i_clk), .i_a(r_kr2), .i_b(r_r2d[9]), .o_p(w_m3));

    always_ff @(posedge i_clk) begin
        r_kr1 <= add_q(w_m1, w_k2);
        r_kr2 <= add_q(w_m2, w_k1);
        r_kr  <= add_q(w_m3, Q_ONE);
        r_r2d[0] <= r_r2;
        for (int k = 1; k < 10; k++) begin
            r_r2d[k] <= r_r2d[k-1];
        end
    end

    // alignment lines up to the final products
    t_q r_dd    [2][20];
    t_q r_sd    [2][14];
    t_q r_dxy2d [15];

    always_ff @(posedge i_clk) begin
        r_dxy2d[0] <= r_dxy2;
        for (int k = 1; k < 15; k++) begin
            r_dxy2d[k] <= r_dxy2d[k-1];
        end
        for (int a = 0; a < 2; a++) begin
            r_dd[a][0] <= r_dq[a];
            r_sd[a][0] <= r_s[a];
            for (int k = 1; k < 20; k++) begin
                r_dd[a][k] <= r_dd[a][k-1];
            end
            for (int k = 1; k < 14; k++) begin
                r_sd[a][k] <= r_sd[a][k-1];
            end
        end
    end

    // distorted normalised point and mapping back to pixels
    t_q                       w_mk  [2];
    t_q                       w_mt1 [2];
    t_q                       w_mt2 [2];
    t_q                       w_mf  [2];
    t_q                       r_acc [2];
    t_q                       r_t2h [2];
    t_q                       r_t   [2];
    logic signed [OUT_W-1:0]  r_o   [2];
    logic signed [OUT_W-1:0]  r_o2  [2];
    logic [11:0]              r_ci  [2];
    logic                     r_in  [2];
    logic signed [OUT_W:0]    n_w   [2];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        ldpm_mulq u_mk  (.i_clk(i_clk), .i_a(r_dd[a][19]), .i_b(r_kr),
                         .o_p(w_mk[a]));
        ldpm_mulq u_mt1 (.i_clk(i_clk), .i_a(w_pa[a]), .i_b(r_sd[a][13]),
                         .o_p(w_mt1[a]));
        ldpm_mulq u_mt2 (.i_clk(i_clk), .i_a(w_pb[a]), .i_b(r_dxy2d[14]),
                         .o_p(w_mt2[a]));
        ldpm_mulq u_mf  (.i_clk(i_clk), .i_a(r_t[a]), .i_b(w_focal_q[a]),
                         .o_p(w_mf[a]));
    end

    // half-pixel offset for rounding
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_w[a] = {r_o[a][OUT_W-1], r_o[a]} + 29'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            r_acc[a] <= add_q(w_mk[a], w_mt1[a]);
            r_t2h[a] <= w_mt2[a];
            r_t[a]   <= add_q(r_acc[a], r_t2h[a]);
            r_o[a]   <= sat_out(w_mf[a], w_center[a]);
            r_o2[a]  <= r_o[a];
            // truncation toward zero: (-1, 0) rounds to column zero
            r_ci[a]  <= n_w[a][OUT_W] ? 12'd0 : n_w[a][OUT_W-1:16];
        end
        r_in[0] <= n_w[0][OUT_W] ? (n_w[0] > -29'sd65536)
                                 : ({1'b0, n_w[0][OUT_W-1:16]} < W_LIM);
        r_in[1] <= n_w[1][OUT_W] ? (n_w[1] > -29'sd65536)
                                 : ({1'b0, n_w[1][OUT_W-1:16]} < H_LIM);
    end

    // linear index and result registers
    logic [24:0]              w_lin;
    logic signed [OUT_W-1:0]  r_out_x, r_out_y;
    logic [17:0]              r_out_idx;
    logic                     r_out_ok;

    assign w_lin = 25'(r_ci[1]) * 25'(IMAGE_WIDTH) + 25'(r_ci[0]);

    always_ff @(posedge i_clk) begin
        r_out_x   <= r_o2[0];
        r_out_y   <= r_o2[1];
        r_out_idx <= (r_in[0] && r_in[1]) ? w_lin[17:0] : 18'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ok <= 1'b0;
        end else begin
            r_out_ok <= r_in[0] && r_in[1] && r_vld[LAT-2];
        end
    end

    assign o_done        = r_vld[LAT-1];
    assign o_distorted_x = r_out_x;
    assign o_distorted_y = r_out_y;
    assign o_map_index   = r_out_idx;
    assign o_index_valid = r_out_ok;

    // every accepted transaction leaves after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_done)
        else $error("result strobe missing after pipeline latency");

    // index valid only travels with a result
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_index_valid |-> o_done)
        else $error("index valid without result strobe");

    // out-of-image results carry a zero index
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_index_valid |-> o_map_index == 18'd0)
        else $error("nonzero index on invalid result");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !o_index_valid)
        else $error("result strobe after reset");

endmodule
`default_nettype wire

### sim/lens_distortion_pixel_map_checker.sv
// ---------------------------------------------------------------------------
// lens_distortion_pixel_map_checker
// Watches the pixel, configuration and result channels of the lens distortion
// core, predicts each distorted coordinate and map index, and compares.
// ---------------------------------------------------------------------------
module lens_distortion_pixel_map_checker
    import ldpm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [8:0]        i_pixel_x,
    input  wire logic [8:0]        i_pixel_y,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [63:0]       i_cfg_wdata,
    input  wire logic              i_done,
    input  wire logic signed [27:0] i_distorted_x,
    input  wire logic signed [27:0] i_distorted_y,
    input  wire logic [17:0]       i_map_index,
    input  wire logic              i_index_valid,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_inside
);

    typedef struct packed {
        logic signed [27:0] dist_x;
        logic signed [27:0] dist_y;
        logic [17:0]        index;
        logic               in_image;
    } t_point;

    localparam logic signed [63:0] BOUND = 64'sh00FF_FFFF_FFFF_FFFF;

    // shadow of the register file
    logic [25:0] cen_x, cen_y, foc_x, foc_y;
    logic [31:0] k1_r, k2_r, k3_r;
    logic [63:0] tan_r;

    t_point expected_points[$];

    function automatic logic signed [63:0] clamp(input logic signed [127:0] v);
        if (v > BOUND) return BOUND;
        if (v < -BOUND) return -BOUND;
        return v[63:0];
    endfunction

    // exact product, truncated toward zero by 28 bits, clamped
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [127:0] p;
        logic [127:0]        m;
        logic signed [127:0] r;
        p = 128'(a) * 128'(b);
        m = (p < 0) ? -p : p;
        m = m >> 28;
        r = (p < 0) ? -$signed(m) : $signed(m);
        return clamp(r);
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        return clamp(128'(a) + 128'(b));
    endfunction

    function automatic logic signed [63:0] norm_coord(input logic [8:0] pix,
                                                      input logic [25:0] cen,
                                                      input logic [25:0] foc);
        logic signed [63:0] u;
        logic [127:0]       q;
        u = $signed({39'd0, pix, 16'd0}) - $signed({38'd0, cen});
        if (u == 0) return 0;
        if (foc == 0) return (u < 0) ? -BOUND : BOUND;
        q = ({64'd0, (u < 0) ? -u : u} << 28) / foc;
        if (q > 128'(BOUND)) q = 128'(BOUND);
        return (u < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] back_to_pixels(input logic signed [63:0] t,
                                                          input logic [25:0] foc,
                                                          input logic [25:0] cen);
        logic signed [63:0] v;
        v = fx_mul(t, $signed({38'd0, foc})) + $signed({38'd0, cen});
        if (v > 64'sd134217727) return 64'sd134217727;
        if (v < -64'sd134217728) return -64'sd134217728;
        return v;
    endfunction

    function automatic logic signed [63:0] nearest_pixel(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd32768;
        return (w < 0) ? -((-w) >>> 16) : (w >>> 16);
    endfunction

    function automatic t_point distort_pixel(input logic [8:0] px, input logic [8:0] py);
        logic signed [63:0] k1, k2, k3, p1, p2;
        logic signed [63:0] dx, dy, dx2, dy2, r2, dxy2, kr, xt, yt, xo, yo, ix, iy;
        t_point res;
        k1 = $signed(k1_r);
        k2 = $signed(k2_r);
        k3 = $signed(k3_r);
        p1 = $signed(tan_r[31:0]);
        p2 = $signed(tan_r[63:32]);
        dx = norm_coord(px, cen_x, foc_x);
        dy = norm_coord(py, cen_y, foc_y);
        dx2 = fx_mul(dx, dx);
        dy2 = fx_mul(dy, dy);
        r2 = fx_add(dx2, dy2);
        dxy2 = clamp(128'(fx_mul(dx, dy)) * 2);
        kr = fx_add(fx_mul(k3, r2), k2);
        kr = fx_add(fx_mul(kr, r2), k1);
        kr = fx_add(fx_mul(kr, r2), 64'sd268435456);
        xt = fx_add(fx_mul(dx, kr), fx_mul(p2, fx_add(r2, clamp(128'(dx2) * 2))));
        xt = fx_add(xt, fx_mul(p1, dxy2));
        yt = fx_add(fx_mul(dy, kr), fx_mul(p1, fx_add(r2, clamp(128'(dy2) * 2))));
        yt = fx_add(yt, fx_mul(p2, dxy2));
        xo = back_to_pixels(xt, foc_x, cen_x);
        yo = back_to_pixels(yt, foc_y, cen_y);
        ix = nearest_pixel(xo);
        iy = nearest_pixel(yo);
        res.dist_x = xo[27:0];
        res.dist_y = yo[27:0];
        res.in_image = (ix >= 0 && ix < DEF_IMAGE_WIDTH && iy >= 0 && iy < DEF_IMAGE_HEIGHT);
        res.index = res.in_image ? 18'(iy * DEF_IMAGE_WIDTH + ix) : 18'd0;
        return res;
    endfunction

    assign o_pending = expected_points.size();

    // register shadow, prediction on each transaction, comparison on each result
    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            cen_x <= RST_CENTER_X;
            cen_y <= RST_CENTER_Y;
            foc_x <= RST_FOCAL;
            foc_y <= RST_FOCAL;
            k1_r  <= '0;
            k2_r  <= '0;
            k3_r  <= '0;
            tan_r <= '0;
            expected_points.delete();
        end else begin
            if (i_done) begin
                if (expected_points.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected result x=%0d y=%0d idx=%0d v=%0b",
                                 i_distorted_x, i_distorted_y, i_map_index, i_index_valid);
                end else begin
                    want = expected_points.pop_front();
                    o_checked = o_checked + 1;
                    if (i_index_valid) o_inside = o_inside + 1;
                    if (want.dist_x !== i_distorted_x || want.dist_y !== i_distorted_y ||
                        want.index !== i_map_index || want.in_image !== i_index_valid) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch: exp x=%0d y=%0d idx=%0d v=%0b, got x=%0d y=%0d idx=%0d v=%0b",
                                     want.dist_x, want.dist_y, want.index, want.in_image,
                                     i_distorted_x, i_distorted_y, i_map_index, i_index_valid);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_points.push_back(distort_pixel(i_pixel_x, i_pixel_y));
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_CENTER_X:      cen_x <= i_cfg_wdata[25:0];
                    REG_CENTER_Y:      cen_y <= i_cfg_wdata[25:0];
                    REG_FOCAL_X:       foc_x <= i_cfg_wdata[25:0];
                    REG_FOCAL_Y:       foc_y <= i_cfg_wdata[25:0];
                    REG_RADIAL_FIRST:  k1_r  <= i_cfg_wdata[31:0];
                    REG_RADIAL_SECOND: k2_r  <= i_cfg_wdata[31:0];
                    REG_RADIAL_THIRD:  k3_r  <= i_cfg_wdata[31:0];
                    REG_TANGENTIAL:    tan_r <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_inside  = 0;
    end

endmodule

### sim/lens_distortion_pixel_map_core_test.sv
// ---------------------------------------------------------------------------
// lens_distortion_pixel_map_core_test
// Drives pixels and register settings into the lens distortion core; the
// checker beside it predicts and compares every result.
// ---------------------------------------------------------------------------
module lens_distortion_pixel_map_core_test;
    import ldpm_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [8:0]        i_pixel_x;
    logic [8:0]        i_pixel_y;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_index;
    logic [63:0]       i_cfg_wdata;
    logic              o_done;
    logic signed [27:0] o_distorted_x;
    logic signed [27:0] o_distorted_y;
    logic [17:0]       o_map_index;
    logic              o_index_valid;
    int                errors, pending, checked, in_image;
    int                idle_pct;

    lens_distortion_pixel_map_core dut (
        .i_clk, .i_rst_n, .start, .busy, .i_pixel_x, .i_pixel_y,
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata, .o_done,
        .o_distorted_x, .o_distorted_y, .o_map_index, .o_index_valid
    );

    lens_distortion_pixel_map_checker checker_u (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_pixel_x, .i_pixel_y, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_done(o_done), .i_distorted_x(o_distorted_x), .i_distorted_y(o_distorted_y),
        .i_map_index(o_map_index), .i_index_valid(o_index_valid),
        .o_errors(errors), .o_pending(pending), .o_checked(checked), .o_inside(in_image)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one pixel transaction, with an optional random gap before it
    task automatic send_pixel(input logic [8:0] px, input logic [8:0] py);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // let the pipeline empty before touching registers
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, with write enable dropped again before the task returns
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // plausible centre, focal and coefficients, sometimes extreme
    task automatic random_setting(input bit wild);
        write_reg(REG_CENTER_X, wild ? 64'($urandom) : 64'($urandom_range(320, 192) << 16));
        write_reg(REG_CENTER_Y, wild ? 64'($urandom) : 64'($urandom_range(260, 160) << 16));
        write_reg(REG_FOCAL_X, wild ? 64'($urandom) : 64'($urandom_range(420, 300) << 16));
        write_reg(REG_FOCAL_Y, wild ? 64'($urandom) : 64'($urandom_range(420, 300) << 16));
        write_reg(REG_RADIAL_FIRST, wild ? 64'($urandom)
                                         : 64'($signed($urandom_range(60000000, 0)) - 30000000));
        write_reg(REG_RADIAL_SECOND, wild ? 64'($urandom)
                                          : 64'($signed($urandom_range(20000000, 0)) - 10000000));
        write_reg(REG_RADIAL_THIRD, wild ? 64'($urandom)
                                         : 64'($signed($urandom_range(4000000, 0)) - 2000000));
        write_reg(REG_TANGENTIAL, wild ? {$urandom, $urandom}
                                       : {32'($signed($urandom_range(600000, 0)) - 300000),
                                          32'($signed($urandom_range(600000, 0)) - 300000)});
    endtask

    task automatic random_pixels(input int count);
        repeat (count) begin
            if ($urandom_range(3, 0) == 0)
                send_pixel(9'($urandom), 9'($urandom));
            else
                send_pixel(9'($urandom_range(511, 0)), 9'($urandom_range(423, 0)));
        end
    endtask

    initial begin
        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_CENTER_X;
        i_cfg_wdata = '0;
        idle_pct    = 33;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners, centre, all-ones inputs with reset registers
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd423);
        send_pixel(9'd256, 9'd212);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        drain();

        // zero focal length and extreme centres: coordinates saturate
        write_reg(REG_FOCAL_X, 64'd0);
        write_reg(REG_FOCAL_Y, 64'd0);
        write_reg(REG_CENTER_X, 64'h3FF_FFFF);
        write_reg(REG_CENTER_Y, 64'd0);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd100, 9'd0);
        drain();

        // smallest focal, maximal coefficients: huge intermediates
        write_reg(REG_FOCAL_X, 64'd1);
        write_reg(REG_FOCAL_Y, 64'h3FF_FFFF);
        write_reg(REG_CENTER_X, 64'd0);
        write_reg(REG_CENTER_Y, 64'h3FF_FFFF);
        write_reg(REG_RADIAL_FIRST, 64'h7FFF_FFFF);
        write_reg(REG_RADIAL_SECOND, 64'h8000_0000);
        write_reg(REG_RADIAL_THIRD, 64'h7FFF_FFFF);
        write_reg(REG_TANGENTIAL, 64'h8000_0000_7FFF_FFFF);
        send_pixel(9'd1, 9'd1);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd257, 9'd300);
        drain();

        // rounding near the lower image edge: unit focal, zero centre, k1 of -1.0
        write_reg(REG_FOCAL_X, 64'd1 << 16);
        write_reg(REG_FOCAL_Y, 64'd1 << 16);
        write_reg(REG_CENTER_X, 64'd0);
        write_reg(REG_CENTER_Y, 64'd0);
        write_reg(REG_RADIAL_FIRST, 64'hFFFF_FFFF_F000_0000);
        write_reg(REG_RADIAL_SECOND, 64'd0);
        write_reg(REG_RADIAL_THIRD, 64'd0);
        write_reg(REG_TANGENTIAL, 64'd0);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd1, 9'd1);
        send_pixel(9'd2, 9'd1);
        send_pixel(9'd511, 9'd423);
        drain();

        // random phases: a no-idle stretch, mostly realistic lens settings
        for (int phase = 0; phase < 12; phase++) begin
            idle_pct = (phase == 2) ? 0 : 33;
            random_setting(phase % 4 == 3);
            random_pixels(50);
            drain();
        end

        $display("checked %0d pixel results, %0d inside the image, over 16 settings",
                 checked, in_image);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### lens_distortion_pixel_map_core.f
rtl/ldpm_pkg.sv
rtl/ldpm_mulq.sv
rtl/lens_distortion_pixel_map_core.sv
sim/lens_distortion_pixel_map_checker.sv
sim/lens_distortion_pixel_map_core_test.sv
